### rtl/msgid_pkg.sv
// Shared types and constants for the message id set table.
// Used by every module of the block; depends on nothing.
package msgid_pkg;

  localparam int unsigned IdW    = 32;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    action_e          op;
    logic [IdW-1:0]   key;
  } cmd_t;

  typedef struct packed {
    logic    found;
    logic    is_empty;
    status_e status;
  } result_t;

endpackage

### rtl/msgid_fifo.sv
// Small two-entry word queue used between the parts of the block.
// Depends on msgid_pkg for the queue depth.
module msgid_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);
  import msgid_pkg::*;

  logic [Width-1:0] mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == QCntW'(QDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_ready_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + QCntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/msgid_front.sv
// Front end: accepts input words, decodes the action and queues commands.
// Depends on msgid_pkg and msgid_fifo.
module msgid_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 action_i,
  input  logic signed [31:0]         msg_id_i,
  input  logic                       cmd_pop_i,
  output msgid_pkg::cmd_t            cmd_o,
  output logic                       cmd_empty_o
);
  import msgid_pkg::*;

  cmd_t cmd_in;

  // Ids are compared as raw bit patterns, so the sign is dropped here.
  always_comb begin
    cmd_in.op  = action_e'(action_i);
    cmd_in.key = $unsigned(msg_id_i);
  end

  msgid_fifo #(
    .Width($bits(cmd_t))
  ) u_cmd_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_data_i  (cmd_in),
    .full_o     (full),
    .rd_ready_i (cmd_pop_i),
    .rd_data_o  (cmd_o),
    .empty_o    (cmd_empty_o)
  );

endmodule

### rtl/msgid_back.sv
// Back end: the id table with parallel compare, executes one command per cycle
// when not stalled and queues its result. Depends on msgid_pkg and msgid_fifo.
module msgid_back #(
  parameter int unsigned Capacity = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msgid_pkg::cmd_t     cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  input  logic                pop,
  output logic                empty,
  output msgid_pkg::result_t  res_o
);
  import msgid_pkg::*;

  logic [IdW-1:0]      ids_q [Capacity];
  logic [Capacity-1:0] valid_q, valid_d;
  logic [Capacity-1:0] hit, hit_first, free, free_first;
  logic                go, res_full, tbl_full, tbl_any;
  result_t             res_d;

  assign go        = !cmd_empty_i && !res_full;
  assign cmd_pop_o = go;

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      hit[i] = valid_q[i] && (ids_q[i] == cmd_i.key);
    end
  end

  // Lowest set bit of each vector selects the entry to touch.
  assign free       = ~valid_q;
  assign free_first = free & (~free + Capacity'(1));
  assign hit_first  = hit & (~hit + Capacity'(1));
  assign tbl_full   = &valid_q;
  assign tbl_any    = |valid_q;

  always_comb begin
    valid_d        = valid_q;
    res_d.found    = 1'b0;
    res_d.status   = ST_OK;
    case (cmd_i.op)
      ACT_INSERT: begin
        if (tbl_full) begin
          res_d.status = ST_FULL;
        end else begin
          valid_d = valid_q | free_first;
        end
      end
      ACT_REMOVE: begin
        if (!tbl_any) begin
          res_d.status = ST_EMPTY;
        end else if (!(|hit)) begin
          res_d.status = ST_NOT_FOUND;
        end else begin
          valid_d = valid_q & ~hit_first;
        end
      end
      ACT_QUERY: begin
        res_d.found = |hit;
      end
      ACT_CLEAR: begin
        valid_d = '0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
    res_d.is_empty = ~(|valid_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (go) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Capacity; i++) begin
      if (go && (cmd_i.op == ACT_INSERT) && free_first[i]) begin
        ids_q[i] <= cmd_i.key;
      end
    end
  end

  msgid_fifo #(
    .Width($bits(result_t))
  ) u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (go),
    .wr_data_i  (res_d),
    .full_o     (res_full),
    .rd_ready_i (pop),
    .rd_data_o  (res_o),
    .empty_o    (empty)
  );

`ifndef NO_ASSERTIONS
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && (cmd_i.op == ACT_CLEAR) |=> (valid_q == '0))
    else $error("table not empty after clear");

  a_insert_adds_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && (cmd_i.op == ACT_INSERT) && !tbl_full |=>
      ($countones(valid_q) == $countones($past(valid_q)) + 1))
    else $error("insert did not add exactly one entry");

  a_full_insert_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && (cmd_i.op == ACT_INSERT) && tbl_full |=> $stable(valid_q))
    else $error("insert into full table changed it");

  a_remove_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && (cmd_i.op == ACT_REMOVE) && (|hit) |=>
      ($countones(valid_q) + 1 == $countones($past(valid_q))))
    else $error("remove did not drop exactly one entry");
`endif

endmodule

### rtl/message_id_set_table.sv
// Top level of the message id set table: a multiset of ids in a small CAM.
// Depends on msgid_pkg, msgid_front and msgid_back.
//
//   channel   direction  handshake        fields
//   command   in         push / full      action_i, msg_id_i
//   result    out        pop / empty      found_o, is_empty_o, status_o
//
// One word per cycle is sustained while neither side stalls; the table's
// combinational compare over all entries in the back end sets that figure.
// A result reaches the result ports once its command has left the command
// queue and the back end has written it into the result queue to be popped.
// Reset empties the table at once through its valid bits.
// Either side may stall; each two-word queue absorbs it separately.
module message_id_set_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] msg_id_i,
  input  logic               pop,
  output logic               empty,
  output logic               found_o,
  output logic               is_empty_o,
  output logic [1:0]         status_o
);
  import msgid_pkg::*;

  cmd_t    cmd;
  logic    cmd_empty, cmd_pop;
  result_t res;

  msgid_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .msg_id_i    (msg_id_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  msgid_back #(
    .Capacity(CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res)
  );

  assign found_o    = res.found;
  assign is_empty_o = res.is_empty;
  assign status_o   = res.status;

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for message_id_set_table, a bounded multiset of message ids.
// Depends on msgid_pkg and the block's RTL; a local table copy predicts untyped replies.
module tb_top;
  import msgid_pkg::*;

  localparam int unsigned Slots      = 16;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseWords = 150;

  typedef struct {
    action_e     op;
    logic [31:0] key;
    int unsigned reps;   // the row is sent reps times with key, key + 1, ...
    bit          typed;  // reply below is the known answer; otherwise predicted
    result_t     reply;
  } step_row_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push   = 1'b0;
  logic        full;
  action_e     action = ACT_INSERT;
  logic [31:0] msg_id = '0;
  logic        pop    = 1'b0;
  logic        empty;
  logic        found;
  logic        is_empty;
  logic [1:0]  status;

  // Local copy of the table that the predictor keeps in step with the block.
  logic [31:0]      table_ids [Slots];
  logic [Slots-1:0] table_valid = '0;

  result_t     replies_due [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 8;
  int unsigned rx_idle_pct = 52;
  int unsigned op_count [4]     = '{default: 0};
  int unsigned status_count [4] = '{default: 0};
  int unsigned hits_seen = 0;

  step_row_t directed_steps [25] = '{
    '{ACT_QUERY,  32'h0000_0000,  1, 1'b1, '{1'b0, 1'b1, ST_OK}},
    '{ACT_REMOVE, 32'h0000_0005,  1, 1'b1, '{1'b0, 1'b1, ST_EMPTY}},
    '{ACT_CLEAR,  32'hFFFF_FFFF,  1, 1'b1, '{1'b0, 1'b1, ST_OK}},
    '{ACT_INSERT, 32'h8000_0000,  1, 1'b1, '{1'b0, 1'b0, ST_OK}},
    '{ACT_INSERT, 32'h7FFF_FFFF,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_INSERT, 32'hFFFF_FFFF,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_INSERT, 32'h0000_0000,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_QUERY,  32'h8000_0000,  1, 1'b1, '{1'b1, 1'b0, ST_OK}},
    '{ACT_QUERY,  32'h8000_0001,  1, 1'b1, '{1'b0, 1'b0, ST_OK}},
    '{ACT_REMOVE, 32'h1234_5678,  1, 1'b1, '{1'b0, 1'b0, ST_NOT_FOUND}},
    '{ACT_INSERT, 32'h7FFF_FFFF,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_REMOVE, 32'h7FFF_FFFF,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_QUERY,  32'h7FFF_FFFF,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_REMOVE, 32'h7FFF_FFFF,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_QUERY,  32'h7FFF_FFFF,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_INSERT, 32'hA5A5_0000, 13, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_INSERT, 32'h5A5A_5A5A,  1, 1'b1, '{1'b0, 1'b0, ST_FULL}},
    '{ACT_REMOVE, 32'hA5A5_000C,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_INSERT, 32'h5A5A_5A5A,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_REMOVE, 32'h5A5A_5A5A,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_CLEAR,  32'h0000_0000,  1, 1'b1, '{1'b0, 1'b1, ST_OK}},
    '{ACT_QUERY,  32'h8000_0000,  1, 1'b1, '{1'b0, 1'b1, ST_OK}},
    '{ACT_REMOVE, 32'h8000_0000,  1, 1'b1, '{1'b0, 1'b1, ST_EMPTY}},
    '{ACT_INSERT, 32'hFFFF_FFFF,  1, 1'b0, '{1'b0, 1'b0, ST_OK}},
    '{ACT_REMOVE, 32'hFFFF_FFFF,  1, 1'b1, '{1'b0, 1'b1, ST_OK}}
  };

  message_id_set_table #(
    .CAPACITY(Slots)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .action_i   (action),
    .msg_id_i   (msg_id),
    .pop        (pop),
    .empty      (empty),
    .found_o    (found),
    .is_empty_o (is_empty),
    .status_o   (status)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d replies outstanding",
               cycle_count, replies_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Applies one command to the local table and returns the reply word it must produce.
  function automatic result_t predict_table_reply(input action_e op, input logic [31:0] key);
    result_t r;
    int      hit;
    int      hole;
    hit  = -1;
    hole = -1;
    // Walking down leaves the lowest matching and the lowest free slot.
    for (int i = Slots - 1; i >= 0; i--) begin
      if (table_valid[i] && table_ids[i] == key) hit = i;
      if (!table_valid[i]) hole = i;
    end
    r.found  = 1'b0;
    r.status = ST_OK;
    case (op)
      ACT_INSERT: begin
        if (hole < 0) begin
          r.status = ST_FULL;
        end else begin
          table_ids[hole]   = key;
          table_valid[hole] = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (table_valid == '0) r.status = ST_EMPTY;
        else if (hit < 0) r.status = ST_NOT_FOUND;
        else table_valid[hit] = 1'b0;
      end
      ACT_QUERY: begin
        r.found = (hit >= 0);
      end
      default: begin
        table_valid = '0;
      end
    endcase
    r.is_empty = (table_valid == '0);
    op_count[op]++;
    status_count[r.status]++;
    if (r.found) hits_seen++;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [1:0] got,
                                 input logic [1:0] want);
    if (mismatches < 50) begin
      $display("Mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    end
    mismatches++;
  endtask

  // The word is taken at the first edge where push is high and full is low.
  task automatic send_word(input action_e op, input logic [31:0] key, input bit typed,
                           input result_t reply);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    action <= op;
    msg_id <= key;
    do @(posedge clk_i); while (full);
    predicted = predict_table_reply(op, key);
    replies_due.push_back(typed ? reply : predicted);
  endtask

  task automatic send_random(input int unsigned words);
    logic [31:0] pool [8];
    int unsigned pick;
    action_e     op;
    logic [31:0] key;
    for (int k = 0; k < 8; k++) pool[k] = $urandom();
    for (int unsigned n = 0; n < words; n++) begin
      pick = $urandom_range(99);
      // The first half leans on inserts so the table fills up; the second half drains it.
      if (n < words / 2) begin
        op = (pick < 55) ? ACT_INSERT : (pick < 75) ? ACT_REMOVE :
             (pick < 98) ? ACT_QUERY : ACT_CLEAR;
      end else begin
        op = (pick < 25) ? ACT_INSERT : (pick < 65) ? ACT_REMOVE :
             (pick < 98) ? ACT_QUERY : ACT_CLEAR;
      end
      // A small set of recurring ids makes hits and duplicate copies common.
      key = ($urandom_range(99) < 75) ? pool[$urandom_range(7)] : $urandom();
      if (n == words / 3) begin
        push <= 1'b0;
        @(posedge clk_i);
        while (replies_due.size() != 0) @(posedge clk_i);
      end
      send_word(op, key, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin : check_replies
    result_t due;
    if (rst_ni && pop && !empty) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply word with nothing due, status", status, 2'd0);
      end else begin
        due = replies_due.pop_front();
        if (found !== due.found) report_mismatch("found", {1'b0, found}, {1'b0, due.found});
        if (is_empty !== due.is_empty) begin
          report_mismatch("is_empty", {1'b0, is_empty}, {1'b0, due.is_empty});
        end
        if (status !== due.status) report_mismatch("status", status, due.status);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[s]) begin
      for (int unsigned k = 0; k < directed_steps[s].reps; k++) begin
        send_word(directed_steps[s].op, directed_steps[s].key + k, directed_steps[s].typed,
                  directed_steps[s].reply);
      end
    end

    send_random(PhaseWords);
    tx_idle_pct = 52;
    rx_idle_pct = 8;
    send_random(PhaseWords);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(PhaseWords);

    push <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Words sent: %0d inserts, %0d removes, %0d queries, %0d clears; %0d query hits",
             op_count[ACT_INSERT], op_count[ACT_REMOVE], op_count[ACT_QUERY],
             op_count[ACT_CLEAR], hits_seen);
    $display("Replies: %0d ok, %0d remove on empty, %0d remove missed, %0d insert on full",
             status_count[ST_OK], status_count[ST_EMPTY], status_count[ST_NOT_FOUND],
             status_count[ST_FULL]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/msgid_pkg.sv
rtl/msgid_fifo.sv
rtl/msgid_front.sv
rtl/msgid_back.sv
rtl/message_id_set_table.sv
sim/tb_top.sv
